[design/nearest_neighbor_scaler_rgb565_macros.svh]
// assertion macros used by the checker file
`ifndef NEAREST_NEIGHBOR_SCALER_RGB565_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALER_RGB565_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NNS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/nns_pkg.sv]
package nns_pkg;

    // default sizing of the scaler
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 512;
    localparam int DEF_FRACTION_BITS = 16;

    // default divider sizing (step width and size width)
    localparam int DEF_STEP_W = 27;
    localparam int DEF_SIZE_W = 11;

    // stream payload widths
    localparam int PIX_W = 24;
    localparam int RGB_W = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int SW_REG_W    = 11;
    localparam int SH_REG_W    = 10;

    localparam logic [SW_REG_W-1:0] RST_SOURCE_WIDTH  = 11'd256;
    localparam logic [SH_REG_W-1:0] RST_SOURCE_HEIGHT = 10'd240;
    localparam logic [SW_REG_W-1:0] RST_OUTPUT_WIDTH  = 11'd256;
    localparam logic [SH_REG_W-1:0] RST_OUTPUT_HEIGHT = 10'd240;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_OUTPUT_WIDTH  = 3'd2,
        CFG_OUTPUT_HEIGHT = 3'd3,
        CFG_DEEP_COLOR    = 3'd4
    } t_cfg_index;

    // bgr555 halfword or bgr888 byte triple to rgb565
    function automatic logic [RGB_W-1:0] to_rgb565(logic [PIX_W-1:0] w, logic deep);
        logic [RGB_W-1:0] res;
        if (deep) begin
            res = {w[7:3], w[15:10], w[23:19]};
        end else begin
            res = {w[4:0], w[9:5], 1'b0, w[14:10]};
        end
        return res;
    endfunction

endpackage

[design/nearest_neighbor_scaler_rgb565.sv]
// nearest-neighbor downscaler, bgr555 / bgr888 source pixels in, rgb565 pixels out
//
// s_axis: source pixels of one window in raster order, tuser marks the first
//   pixel of a window; the window sizes are sampled on that pixel
// m_axis: picked pixels in rgb565, tlast ends an output row, tuser ends the picture
// cfg:    i_cfg_we / i_cfg_index / i_cfg_data write source and output sizes and the
//   color mode; the color mode applies to every pixel as it arrives
//
// throughput: one source pixel per clock while s_axis_tready is high; an accepted
//   item reaches the output register on the next clock (many items give no result)
// the column and row steps come from two serial restoring dividers that run
//   after reset and after any size write: s_axis_tready stays low while they work
// reset clears the window state and loads the default register values
// when m_axis stalls with a result waiting, s_axis_tready drops and the
//   output register holds its item until it is taken
module nearest_neighbor_scaler_rgb565 #(
    parameter int MAX_WIDTH     = nns_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = nns_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = nns_pkg::DEF_FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [nns_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nns_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // source pixel stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [nns_pkg::PIX_W-1:0]      s_axis_tdata,   // pixel_word
    input  logic [0:0]                     s_axis_tuser,   // frame_start
    // scaled pixel stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nns_pkg::RGB_W-1:0]      m_axis_tdata,   // rgb565
    output logic                           m_axis_tlast,   // end_of_line
    output logic [0:0]                     m_axis_tuser    // end_of_frame
);

    localparam int SWR = nns_pkg::SW_REG_W;
    localparam int SHR = nns_pkg::SH_REG_W;

    // size widths: effective sizes hold up to the maximum itself
    localparam int EW   = $clog2(MAX_WIDTH + 1);
    localparam int EHW  = $clog2(MAX_HEIGHT + 1);
    // source position counters
    localparam int SC_W = $clog2(MAX_WIDTH);
    localparam int SR_W = $clog2(MAX_HEIGHT);
    // integer part of the accumulators, with headroom for the last step
    localparam int PW   = $clog2(MAX_WIDTH) + 1;
    localparam int RPW  = $clog2(MAX_HEIGHT) + 1;
    localparam int ACC_W  = PW + FRACTION_BITS;
    localparam int RACC_W = RPW + FRACTION_BITS;
    // compare widths for saturation of register values
    localparam int CMPW = (EW > SWR) ? EW : SWR;
    localparam int CMPH = (EHW > SHR) ? EHW : SHR;

    localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
    localparam logic [CMPH-1:0] MAX_H_C = CMPH'(MAX_HEIGHT);

    // configuration registers
    logic [SWR-1:0] r_cfg_sw;
    logic [SHR-1:0] r_cfg_sh;
    logic [SWR-1:0] r_cfg_ow;
    logic [SHR-1:0] r_cfg_oh;
    logic           r_cfg_deep;
    logic           r_div_req;
    logic           w_div_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw   <= nns_pkg::RST_SOURCE_WIDTH;
            r_cfg_sh   <= nns_pkg::RST_SOURCE_HEIGHT;
            r_cfg_ow   <= nns_pkg::RST_OUTPUT_WIDTH;
            r_cfg_oh   <= nns_pkg::RST_OUTPUT_HEIGHT;
            r_cfg_deep <= 1'b0;
            r_div_req  <= 1'b1;     // steps for the default sizes
        end else begin
            if (w_div_start) begin
                r_div_req <= 1'b0;
            end
            if (i_cfg_we) begin
                case (nns_pkg::t_cfg_index'(i_cfg_index))
                    nns_pkg::CFG_SOURCE_WIDTH: begin
                        r_cfg_sw  <= i_cfg_data[SWR-1:0];
                        r_div_req <= 1'b1;
                    end
                    nns_pkg::CFG_SOURCE_HEIGHT: begin
                        r_cfg_sh  <= i_cfg_data[SHR-1:0];
                        r_div_req <= 1'b1;
                    end
                    nns_pkg::CFG_OUTPUT_WIDTH: begin
                        r_cfg_ow  <= i_cfg_data[SWR-1:0];
                        r_div_req <= 1'b1;
                    end
                    nns_pkg::CFG_OUTPUT_HEIGHT: begin
                        r_cfg_oh  <= i_cfg_data[SHR-1:0];
                        r_div_req <= 1'b1;
                    end
                    nns_pkg::CFG_DEEP_COLOR: begin
                        r_cfg_deep <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // effective sizes: zero reads as one, source saturates to the maximum,
    // output saturates to the source
    logic [EW-1:0]  w_eff_sw, w_eff_ow;
    logic [EHW-1:0] w_eff_sh, w_eff_oh;
    logic [CMPW-1:0] w_sw_x, w_ow_x, w_swe_x;
    logic [CMPH-1:0] w_sh_x, w_oh_x, w_she_x;

    always_comb begin
        w_sw_x = CMPW'(r_cfg_sw);
        if (w_sw_x == '0) begin
            w_eff_sw = EW'(1);
        end else if (w_sw_x > MAX_W_C) begin
            w_eff_sw = EW'(MAX_W_C);
        end else begin
            w_eff_sw = EW'(w_sw_x);
        end
        w_swe_x = CMPW'(w_eff_sw);
        w_ow_x  = CMPW'(r_cfg_ow);
        if (w_ow_x == '0) begin
            w_eff_ow = EW'(1);
        end else if (w_ow_x > w_swe_x) begin
            w_eff_ow = w_eff_sw;
        end else begin
            w_eff_ow = EW'(w_ow_x);
        end

        w_sh_x = CMPH'(r_cfg_sh);
        if (w_sh_x == '0) begin
            w_eff_sh = EHW'(1);
        end else if (w_sh_x > MAX_H_C) begin
            w_eff_sh = EHW'(MAX_H_C);
        end else begin
            w_eff_sh = EHW'(w_sh_x);
        end
        w_she_x = CMPH'(w_eff_sh);
        w_oh_x  = CMPH'(r_cfg_oh);
        if (w_oh_x == '0) begin
            w_eff_oh = EHW'(1);
        end else if (w_oh_x > w_she_x) begin
            w_eff_oh = w_eff_sh;
        end else begin
            w_eff_oh = EHW'(w_oh_x);
        end
    end

    // step dividers: (size << fraction) / output size
    logic              w_cbusy, w_rbusy;
    logic [ACC_W-1:0]  w_cstep;
    logic [RACC_W-1:0] w_rstep;

    assign w_div_start = r_div_req && !w_cbusy && !w_rbusy;

    nns_div #(
        .N_W (ACC_W),
        .D_W (EW)
    ) u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({PW'(w_eff_sw), {FRACTION_BITS{1'b0}}}),
        .i_divisor  (w_eff_ow),
        .o_busy     (w_cbusy),
        .o_quotient (w_cstep)
    );

    nns_div #(
        .N_W (RACC_W),
        .D_W (EHW)
    ) u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({RPW'(w_eff_sh), {FRACTION_BITS{1'b0}}}),
        .i_divisor  (w_eff_oh),
        .o_busy     (w_rbusy),
        .o_quotient (w_rstep)
    );

    // picked coordinate (clamped to the last pixel) equals the position
    function automatic logic pick_col(logic [ACC_W-1:0] acc, logic [EW-1:0] size,
                                      logic [SC_W-1:0] pos);
        logic [PW-1:0] p, s, q;
        p = acc[ACC_W-1:FRACTION_BITS];
        s = PW'(size);
        q = PW'(pos);
        return (p >= s) ? (q == s - PW'(1)) : (q == p);
    endfunction

    function automatic logic pick_row(logic [RACC_W-1:0] acc, logic [EHW-1:0] size,
                                      logic [SR_W-1:0] pos);
        logic [RPW-1:0] p, s, q;
        p = acc[RACC_W-1:FRACTION_BITS];
        s = RPW'(size);
        q = RPW'(pos);
        return (p >= s) ? (q == s - RPW'(1)) : (q == p);
    endfunction

    // window state
    logic              r_active, n_active;
    logic              r_row_picked, n_row_picked;
    logic [EW-1:0]     r_eff_sw, n_eff_sw, r_eff_ow, n_eff_ow;
    logic [EHW-1:0]    r_eff_sh, n_eff_sh, r_eff_oh, n_eff_oh;
    logic [ACC_W-1:0]  r_cstep, n_cstep, r_cacc, n_cacc;
    logic [RACC_W-1:0] r_rstep, n_rstep, r_racc, n_racc;
    logic [SC_W-1:0]   r_sc, n_sc;
    logic [SR_W-1:0]   r_sr, n_sr;
    logic [EW-1:0]     r_oc, n_oc;
    logic [EHW-1:0]    r_or, n_or;

    // output register
    logic                      r_m_valid;
    logic [nns_pkg::RGB_W-1:0] r_m_data;
    logic                      r_m_last;
    logic                      r_m_eof;

    logic w_accept;
    logic w_start;
    logic w_emit, w_eol, w_eof;

    // current values: on a frame start the freshly derived ones
    logic              c_active, c_rp;
    logic [EW-1:0]     c_sw, c_ow, c_oc;
    logic [EHW-1:0]    c_sh, c_oh, c_or;
    logic [ACC_W-1:0]  c_cstep, c_cacc;
    logic [RACC_W-1:0] c_rstep, c_racc;
    logic [SC_W-1:0]   c_sc;
    logic [SR_W-1:0]   c_sr;
    logic [EW-1:0]     w_sc1;
    logic [EHW-1:0]    w_sr1;

    assign s_axis_tready = !r_div_req && !w_cbusy && !w_rbusy &&
                           (!r_m_valid || m_axis_tready);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_start  = s_axis_tuser[0];

    always_comb begin
        c_active = w_start || r_active;
        c_sw     = w_start ? w_eff_sw : r_eff_sw;
        c_ow     = w_start ? w_eff_ow : r_eff_ow;
        c_sh     = w_start ? w_eff_sh : r_eff_sh;
        c_oh     = w_start ? w_eff_oh : r_eff_oh;
        c_cstep  = w_start ? w_cstep : r_cstep;
        c_rstep  = w_start ? w_rstep : r_rstep;
        c_cacc   = w_start ? (w_cstep >> 1) : r_cacc;
        c_racc   = w_start ? (w_rstep >> 1) : r_racc;
        c_sc     = w_start ? '0 : r_sc;
        c_sr     = w_start ? '0 : r_sr;
        c_oc     = w_start ? '0 : r_oc;
        c_or     = w_start ? '0 : r_or;
        // first row: output row zero is always below the output height
        c_rp     = w_start ? pick_row(w_rstep >> 1, w_eff_sh, '0) : r_row_picked;

        w_emit = c_active && c_rp && (c_oc < c_ow) && pick_col(c_cacc, c_sw, c_sc);
        w_eol  = c_oc == c_ow - EW'(1);
        w_eof  = w_eol && (c_or == c_oh - EHW'(1));
        w_sc1  = EW'(c_sc) + EW'(1);
        w_sr1  = EHW'(c_sr) + EHW'(1);

        n_active     = r_active;
        n_row_picked = r_row_picked;
        n_eff_sw     = r_eff_sw;
        n_eff_ow     = r_eff_ow;
        n_eff_sh     = r_eff_sh;
        n_eff_oh     = r_eff_oh;
        n_cstep      = r_cstep;
        n_rstep      = r_rstep;
        n_cacc       = r_cacc;
        n_racc       = r_racc;
        n_sc         = r_sc;
        n_sr         = r_sr;
        n_oc         = r_oc;
        n_or         = r_or;

        if (w_accept && c_active) begin
            n_active     = 1'b1;
            n_row_picked = c_rp;
            n_eff_sw     = c_sw;
            n_eff_ow     = c_ow;
            n_eff_sh     = c_sh;
            n_eff_oh     = c_oh;
            n_cstep      = c_cstep;
            n_rstep      = c_rstep;
            n_cacc       = c_cacc;
            n_racc       = c_racc;
            n_oc         = c_oc;
            n_or         = c_or;
            n_sr         = c_sr;

            if (w_emit) begin
                n_cacc = c_cacc + c_cstep;
                n_oc   = c_oc + EW'(1);
            end

            if (w_sc1 >= c_sw) begin
                // end of a source row
                n_sc   = '0;
                n_cacc = c_cstep >> 1;
                if (c_rp) begin
                    n_or   = c_or + EHW'(1);
                    n_racc = c_racc + c_rstep;
                    n_oc   = '0;
                end
                if (w_sr1 >= c_sh) begin
                    n_active     = 1'b0;
                    n_row_picked = 1'b0;
                    n_sr         = c_sr;
                end else begin
                    n_sr         = w_sr1[SR_W-1:0];
                    n_row_picked = (n_or < c_oh) &&
                                   pick_row(n_racc, c_sh, w_sr1[SR_W-1:0]);
                end
            end else begin
                n_sc = w_sc1[SC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_row_picked <= 1'b0;
            r_eff_sw     <= EW'(1);
            r_eff_ow     <= EW'(1);
            r_eff_sh     <= EHW'(1);
            r_eff_oh     <= EHW'(1);
            r_cstep      <= '0;
            r_rstep      <= '0;
            r_cacc       <= '0;
            r_racc       <= '0;
            r_sc         <= '0;
            r_sr         <= '0;
            r_oc         <= '0;
            r_or         <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_row_picked <= n_row_picked;
            r_eff_sw     <= n_eff_sw;
            r_eff_ow     <= n_eff_ow;
            r_eff_sh     <= n_eff_sh;
            r_eff_oh     <= n_eff_oh;
            r_cstep      <= n_cstep;
            r_rstep      <= n_rstep;
            r_cacc       <= n_cacc;
            r_racc       <= n_racc;
            r_sc         <= n_sc;
            r_sr         <= n_sr;
            r_oc         <= n_oc;
            r_or         <= n_or;
            // accept implies the output register is free or being drained
            if (w_accept) begin
                r_m_valid <= w_emit;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_m_data <= nns_pkg::to_rgb565(s_axis_tdata, r_cfg_deep);
            r_m_last <= w_eol;
            r_m_eof  <= w_eof;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tlast    = r_m_last;
    assign m_axis_tuser[0] = r_m_eof;

endmodule

[design/nns_div.sv]
module nns_div #(
    parameter int N_W = nns_pkg::DEF_STEP_W,
    parameter int D_W = nns_pkg::DEF_SIZE_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_busy,
    output logic [N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_div;

    logic [D_W:0] w_shift;
    logic [D_W:0] w_diff;
    logic         w_ge;

    // restoring division, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[N_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= '0;
            r_div <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(N_W);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

[design/nns_checker.sv]
`include "nearest_neighbor_scaler_rgb565_macros.svh"

module nns_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [nns_pkg::RGB_W-1:0]       m_axis_tdata,   // rgb565
    input logic                            m_axis_tlast,   // end_of_line
    input logic [0:0]                      m_axis_tuser    // end_of_frame
);

    // a stalled result holds
    `NNS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser),
        "stalled result changed")

    // end of picture is always also end of a row
    `NNS_ASSERT_IMP(a_eof_eol, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast, "end of frame without end of line")

    // a new result needs an item accepted the cycle before
    `NNS_ASSERT_IMP(a_out_cause, i_clk, i_rst_n, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready), "result without an accepted item")

    // a taken result with no item behind it leaves the output empty
    `NNS_ASSERT_NXT(a_out_drain, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready),
        !m_axis_tvalid, "output not drained")

    // a blocked output register blocks the input
    `NNS_ASSERT_IMP(a_back_press, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready, "item accepted while result stalled")

endmodule

bind nearest_neighbor_scaler_rgb565 nns_checker u_nns_checker (.*);
